[design/pffa_pkg.sv]
// shared types and constants of the page first-fit allocator
// no dependencies; imported by pffa_walk_unit and the top level
package pffa_pkg;

  localparam int MAX_PAGE_BYTES = 4096;
  localparam int HEADER_BYTES   = 8;

  localparam int ADDR_W = $clog2(MAX_PAGE_BYTES);  // header store address
  localparam int SIZE_W = ADDR_W;                  // block data size
  localparam int HDR_W  = SIZE_W + 1;              // size plus free mark
  localparam int REQ_W  = 13;                      // request and page size fields
  localparam int OFF_W  = ADDR_W + 2;              // walk offset, room for overshoot

  localparam logic OP_FORMAT = 1'b0;
  localparam logic OP_ALLOC  = 1'b1;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  // status from the shared walk unit to the sequencer
  typedef struct packed {
    logic              in_range;
    logic              fit_exact;
    logic              fit_split;
    logic [OFF_W-1:0]  next_off;
    logic [ADDR_W-1:0] split_addr;
    logic [SIZE_W-1:0] rest;
  } walk_res_t;

endpackage

[design/pffa_ram.sv]
// generic single-write, single-read ram with registered read data
// depends on nothing
module pffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/pffa_walk_unit.sv]
// shared add/compare unit for the chain walk: fit checks and offset sums
// depends on pffa_pkg
module pffa_walk_unit (
  input  logic [pffa_pkg::OFF_W-1:0] off,
  input  pffa_pkg::hdr_t             hdr,
  input  logic [pffa_pkg::REQ_W-1:0] req,
  input  logic [pffa_pkg::REQ_W-1:0] limit,
  output pffa_pkg::walk_res_t        res
);
  import pffa_pkg::*;

  localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_PAGE_BYTES);

  logic [OFF_W-1:0] off_h;
  logic [OFF_W-1:0] req_h;
  logic [OFF_W-1:0] size_x;
  logic [OFF_W-1:0] req_x;
  logic [OFF_W-1:0] split_sum;
  logic [OFF_W-1:0] rest_x;

  always_comb begin
    size_x    = OFF_W'(hdr.size);
    req_x     = OFF_W'(req);
    off_h     = off + HDR_OFF;
    req_h     = req_x + HDR_OFF;
    split_sum = off_h + req_x;
    rest_x    = size_x - req_h;

    res.in_range   = (off_h <= OFF_W'(limit)) && (off < MAX_OFF);
    res.fit_exact  = hdr.free && (size_x == req_x);
    res.fit_split  = hdr.free && (size_x >= req_h);
    res.next_off   = off_h + size_x;
    res.split_addr = split_sum[ADDR_W-1:0];
    res.rest       = rest_x[SIZE_W-1:0];
  end

endmodule

[design/page_first_fit_allocator_unit.sv]
// top level of the page first-fit allocator: sequencer, header store, walk unit
// depends on pffa_pkg, pffa_ram, pffa_walk_unit
//
// channel | dir | width                  | contents
// in_     | in  | tuser 1, tdata 16      | operation; request_size
// out_    | out | tuser 1, tdata 16      | granted; data_offset
// cfg_    | in  | data 13                | page_size
//
// format: accept, S_FMT header write, then the result in S_OUT; allocate before any format is refused at once
// allocate: each block visited passes S_RD (header read) and S_EVAL (its registered data); an exact fit
// goes to S_OUT, a split fit passes S_SPLIT for the rest header write, a failed range check in S_RD goes to S_OUT
// header store has no reset; only headers written by a format or split are read.
// in_tready is low from accept until the result transfer on out_.
// cfg_ready is always high; page_size takes effect at the next format.
module page_first_fit_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] operation
  input  logic [15:0] in_tdata,   // [12:0] request_size
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [0:0]  out_tuser,  // [0] granted
  output logic [15:0] out_tdata,  // [11:0] data_offset
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data    // page_size
);
  import pffa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FMT, S_RD, S_EVAL, S_SPLIT, S_OUT
  } state_t;

  localparam logic [REQ_W-1:0]  LIM_MAX = REQ_W'(MAX_PAGE_BYTES);
  localparam logic [REQ_W-1:0]  LIM_MIN = REQ_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HDR_A   = ADDR_W'(HEADER_BYTES);

  state_t            state_r, state_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [REQ_W-1:0]  limit_r, limit_nxt;
  logic [REQ_W-1:0]  page_size_r;
  logic              page_ready_r, page_ready_nxt;
  logic [SIZE_W-1:0] rest_r, rest_nxt;
  logic [ADDR_W-1:0] split_addr_r, split_addr_nxt;
  logic              granted_r, granted_nxt;
  logic [ADDR_W-1:0] offset_r, offset_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  hdr_t              ram_wdata;
  hdr_t              ram_rdata;
  logic [HDR_W-1:0]  ram_rbits;
  walk_res_t         walk;
  logic [REQ_W-1:0]  lim_sat;
  logic [REQ_W-1:0]  fmt_size;

  pffa_ram #(
    .WIDTH (HDR_W),
    .DEPTH (MAX_PAGE_BYTES)
  ) u_hdr_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (off_r[ADDR_W-1:0]),
    .rdata (ram_rbits)
  );

  assign ram_rdata = hdr_t'(ram_rbits);

  pffa_walk_unit u_walk (
    .off   (off_r),
    .hdr   (ram_rdata),
    .req   (req_r),
    .limit (limit_r),
    .res   (walk)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = granted_r;
  assign out_tdata  = 16'(offset_r);
  assign cfg_ready  = 1'b1;

  always_comb begin
    if (page_size_r > LIM_MAX) begin
      lim_sat = LIM_MAX;
    end else if (page_size_r < LIM_MIN) begin
      lim_sat = LIM_MIN;
    end else begin
      lim_sat = page_size_r;
    end
    fmt_size = limit_r - LIM_MIN;
  end

  always_comb begin
    state_nxt      = state_r;
    off_nxt        = off_r;
    req_nxt        = req_r;
    limit_nxt      = limit_r;
    page_ready_nxt = page_ready_r;
    rest_nxt       = rest_r;
    split_addr_nxt = split_addr_r;
    granted_nxt    = granted_r;
    offset_nxt     = offset_r;
    ram_we         = 1'b0;
    ram_waddr      = off_r[ADDR_W-1:0];
    ram_wdata      = '{free: 1'b0, size: ram_rdata.size};

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt     = in_tdata[REQ_W-1:0];
          off_nxt     = '0;
          granted_nxt = 1'b0;
          offset_nxt  = '0;
          if (in_tuser[0] == OP_FORMAT) begin
            limit_nxt = lim_sat;
            state_nxt = S_FMT;
          end else if (page_ready_r) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_FMT: begin
        ram_we         = 1'b1;
        ram_waddr      = '0;
        ram_wdata      = '{free: 1'b1, size: fmt_size[SIZE_W-1:0]};
        page_ready_nxt = 1'b1;
        granted_nxt    = 1'b1;
        state_nxt      = S_OUT;
      end
      S_RD: begin
        // header read issued at off_r; data is back in S_EVAL
        if (walk.in_range) begin
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_EVAL: begin
        if (walk.fit_exact) begin
          ram_we      = 1'b1;
          granted_nxt = 1'b1;
          offset_nxt  = off_r[ADDR_W-1:0] + HDR_A;
          state_nxt   = S_OUT;
        end else if (walk.fit_split) begin
          ram_we         = 1'b1;
          ram_wdata      = '{free: 1'b0, size: req_r[SIZE_W-1:0]};
          rest_nxt       = walk.rest;
          split_addr_nxt = walk.split_addr;
          granted_nxt    = 1'b1;
          offset_nxt     = off_r[ADDR_W-1:0] + HDR_A;
          state_nxt      = S_SPLIT;
        end else begin
          off_nxt   = walk.next_off;
          state_nxt = S_RD;
        end
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = split_addr_r;
        ram_wdata = '{free: 1'b1, size: rest_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      page_ready_r <= 1'b0;
      page_size_r  <= REQ_W'(MAX_PAGE_BYTES);
      limit_r      <= '0;
      granted_r    <= 1'b0;
      offset_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      page_ready_r <= page_ready_nxt;
      limit_r      <= limit_nxt;
      granted_r    <= granted_nxt;
      offset_r     <= offset_nxt;
      if (cfg_valid && cfg_ready) begin
        page_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r        <= off_nxt;
    req_r        <= req_nxt;
    rest_r       <= rest_nxt;
    split_addr_r <= split_addr_nxt;
  end

  // input and result sides never handshake-open at once
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // a waiting result holds still until it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tuser) && $stable(out_tdata)))
    else $error("result changed while waiting");

  // a split write always follows a granting evaluation
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> (granted_r && $past(state_r == S_EVAL)))
    else $error("split write without a granted fit");

  // the header store is only written while an item is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (!in_tready && !out_tvalid))
    else $error("header write outside an item");

endmodule
